FILE: design/voxel_ray_traversal_unit_assert.svh
// Assertion macros for the voxel ray walker.
`ifndef VOXEL_RAY_TRAVERSAL_UNIT_ASSERT_SVH
`define VOXEL_RAY_TRAVERSAL_UNIT_ASSERT_SVH

// Check that cons holds in the same cycle as ante.
`define VRT_CHECK_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Check that cons holds in the cycle after ante.
`define VRT_CHECK_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/vrt_pkg.sv
package vrt_pkg;

  localparam int WORLD_HEIGHT = 256;
  localparam logic [15:0] REACH_RESET = 16'd1280;
  localparam logic [31:0] UNIT_ONE = 32'd16384;
  localparam logic [31:0] HIT_T_MIN = 32'd655;

  localparam logic OP_START = 1'b0;
  localparam logic OP_ANSWER = 1'b1;

  localparam logic [1:0] RK_QUERY = 2'd0;
  localparam logic [1:0] RK_HIT = 2'd1;
  localparam logic [1:0] RK_MISS = 2'd2;
  localparam logic [1:0] RK_IGNORED = 2'd3;

  // divider passes during setup
  localparam logic [1:0] PH_MAG = 2'd0;
  localparam logic [1:0] PH_DELTA = 2'd1;
  localparam logic [1:0] PH_SIDE = 2'd2;

  typedef struct packed {
    logic operation;
    logic signed [31:0] start_x;
    logic signed [31:0] start_y;
    logic signed [31:0] start_z;
    logic signed [15:0] dir_x;
    logic signed [15:0] dir_y;
    logic signed [15:0] dir_z;
    logic [7:0] block_kind;
  } req_word_t;

  typedef struct packed {
    logic [1:0] result_kind;
    logic signed [15:0] voxel_x;
    logic [7:0] voxel_y;
    logic signed [15:0] voxel_z;
    logic [1:0] face_axis;
    logic face_negative;
    logic [7:0] hit_kind;
    logic signed [31:0] hit_x;
    logic signed [31:0] hit_y;
    logic signed [31:0] hit_z;
  } rsp_word_t;

endpackage

FILE: design/vrt_req_if.sv
interface vrt_req_if;
  logic valid;
  logic ready;
  vrt_pkg::req_word_t word;
  modport source(output valid, output word, input ready);
  modport sink(input valid, input word, output ready);
endinterface

FILE: design/vrt_rsp_if.sv
interface vrt_rsp_if;
  logic valid;
  logic ready;
  vrt_pkg::rsp_word_t word;
  modport source(output valid, output word, input ready);
  modport sink(input valid, input word, output ready);
endinterface

FILE: design/vrt_cfg_if.sv
interface vrt_cfg_if;
  logic valid;
  logic ready;
  logic [15:0] data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

FILE: design/voxel_ray_traversal_unit.sv
// A start word takes the squared length, 30 root steps and nine divider passes on the one
// shared subtractor, then emits its result; a zero direction misses after the length pass.
// A block answer steps once, computes a hit point, or is ignored. One word at a time:
// req.ready rises together with rsp.valid, and the emit waits while the output register
// still holds an unread word.
// Reset (rst, synchronous, active high): no active ray, reach 1280, output empty.
module voxel_ray_traversal_unit (
  input logic clk,
  input logic rst,
  vrt_cfg_if.sink cfg,
  vrt_req_if.sink req,
  vrt_rsp_if.source rsp
);
  import vrt_pkg::*;

  typedef enum logic [10:0] {
    S_IDLE     = 11'b000_0000_0001,
    S_SQ_MUL   = 11'b000_0000_0010,
    S_SQ_ACC   = 11'b000_0000_0100,
    S_ROOT     = 11'b000_0000_1000,
    S_DIV_LOAD = 11'b000_0001_0000,
    S_DIV_RUN  = 11'b000_0010_0000,
    S_CHECK    = 11'b000_0100_0000,
    S_STEP     = 11'b000_1000_0000,
    S_HIT_MUL  = 11'b001_0000_0000,
    S_HIT_ADD  = 11'b010_0000_0000,
    S_EMIT     = 11'b100_0000_0000
  } state_t;

  state_t state;

  // configuration
  logic [15:0] reach;

  // ray state
  logic ray_active;
  logic [15:0] cur_voxel [3];
  logic [31:0] side_dist [3];
  logic [31:0] delta_dist [3];
  logic step_sign [3];
  logic [31:0] origin [3];
  logic [14:0] au [3];
  logic [15:0] dir [3];
  logic [31:0] ray_param;
  logic [15:0] steps_taken;
  logic [2:0] last_face;
  logic [7:0] kind_r;
  logic [31:0] hit_pt [3];
  logic [1:0] res_kind;

  // sequencer working registers
  logic [1:0] ax;
  logic [1:0] phase;
  logic [4:0] cnt;
  logic [31:0] sum;
  logic [47:0] prod;
  logic [31:0] rad;
  logic [29:0] root;
  logic [31:0] rem;
  logic [31:0] dsh;
  logic [31:0] q;
  logic [29:0] divisor;

  logic rsp_valid;
  rsp_word_t rsp_word;
  rsp_word_t rsp_word_next;

  // shared compare / subtract unit: root steps and divider steps
  logic [33:0] sub_a;
  logic [33:0] sub_b;
  logic [33:0] sub_diff;
  logic sub_ge;

  always_comb begin
    if (state == S_ROOT) begin
      sub_a = {rem, rad[31:30]};
      sub_b = {2'b00, root, 2'b01};
    end else begin
      sub_a = {3'b000, rem[29:0], dsh[31]};
      sub_b = {4'b0000, divisor};
    end
    sub_ge = (sub_a >= sub_b);
    sub_diff = sub_a - sub_b;
  end

  // shared multiplier
  logic [15:0] ad;
  logic [31:0] mul_a;
  logic [15:0] mul_b;

  always_comb begin
    ad = dir[ax][15] ? (~dir[ax] + 16'd1) : dir[ax];
    if (state == S_HIT_MUL) begin
      mul_a = ray_param;
      mul_b = {1'b0, au[ax]};
    end else begin
      mul_a = {16'd0, ad};
      mul_b = ad;
    end
  end

  // divider load values and final quotient
  logic [31:0] q_fin;
  logic [14:0] magc;
  logic [16:0] gap;
  logic [15:0] frac;

  always_comb begin
    q_fin = {q[30:0], sub_ge};
    magc = (q_fin > UNIT_ONE) ? UNIT_ONE[14:0] : q_fin[14:0];
    frac = origin[ax][15:0];
    gap = step_sign[ax] ? {1'b0, frac} : (17'h10000 - {1'b0, frac});
  end

  // step axis: smallest side distance, ties go to the later axis
  logic [1:0] sel;
  logic [32:0] side_sum;
  logic [15:0] max_steps;
  logic ray_done;

  always_comb begin
    if (side_dist[0] < side_dist[1] && side_dist[0] < side_dist[2]) begin
      sel = 2'd0;
    end else if (side_dist[1] < side_dist[2]) begin
      sel = 2'd1;
    end else begin
      sel = 2'd2;
    end
    side_sum = {1'b0, side_dist[sel]} + {1'b0, delta_dist[sel]};
    max_steps = {7'd0, reach[15:7]} + 16'd1;
    // a set sign bit is below the floor; otherwise compare against the ceiling
    ray_done = (steps_taken >= max_steps) || (ray_param >= {8'd0, reach, 8'd0}) ||
               cur_voxel[1][15] || (cur_voxel[1] >= 16'(WORLD_HEIGHT));
  end

  logic [31:0] off;
  assign off = prod[45:14];

  // result word for the pending kind; fields not used by that kind stay zero
  always_comb begin
    rsp_word_next = '0;
    rsp_word_next.result_kind = res_kind;
    if (res_kind == RK_QUERY || res_kind == RK_HIT) begin
      rsp_word_next.voxel_x = cur_voxel[0];
      rsp_word_next.voxel_y = cur_voxel[1][7:0];
      rsp_word_next.voxel_z = cur_voxel[2];
    end
    if (res_kind == RK_HIT) begin
      rsp_word_next.face_axis = last_face[1:0];
      rsp_word_next.face_negative = last_face[2];
      rsp_word_next.hit_kind = kind_r;
      rsp_word_next.hit_x = hit_pt[0];
      rsp_word_next.hit_y = hit_pt[1];
      rsp_word_next.hit_z = hit_pt[2];
    end
  end

  assign req.ready = (state == S_IDLE);
  assign cfg.ready = 1'b1;
  assign rsp.valid = rsp_valid;
  assign rsp.word = rsp_word;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      reach <= REACH_RESET;
      ray_active <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      if (cfg.valid) begin
        reach <= cfg.data;
      end
      // drop the taken word unless a new one is loaded in the same cycle
      if (rsp_valid && rsp.ready && state != S_EMIT) begin
        rsp_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (req.valid) begin
            kind_r <= req.word.block_kind;
            ax <= 2'd0;
            if (req.word.operation == OP_START) begin
              // capture the ray; a zero direction drops it after the length pass
              dir[0] <= req.word.dir_x;
              dir[1] <= req.word.dir_y;
              dir[2] <= req.word.dir_z;
              origin[0] <= req.word.start_x;
              origin[1] <= req.word.start_y;
              origin[2] <= req.word.start_z;
              cur_voxel[0] <= req.word.start_x[31:16];
              cur_voxel[1] <= req.word.start_y[31:16];
              cur_voxel[2] <= req.word.start_z[31:16];
              sum <= 32'd0;
              state <= S_SQ_MUL;
            end else if (!ray_active) begin
              res_kind <= RK_IGNORED;
              state <= S_EMIT;
            end else if (req.word.block_kind != 8'd0 && ray_param > HIT_T_MIN) begin
              state <= S_HIT_MUL;
            end else begin
              state <= S_STEP;
            end
          end
        end

        S_SQ_MUL: begin
          prod <= {16'd0, mul_a} * {32'd0, mul_b};
          state <= S_SQ_ACC;
        end

        S_SQ_ACC: begin
          sum <= sum + prod[31:0];
          if (ax == 2'd2) begin
            ax <= 2'd0;
            if (sum + prod[31:0] == 32'd0) begin
              ray_active <= 1'b0;
              res_kind <= RK_MISS;
              state <= S_EMIT;
            end else begin
              rad <= sum + prod[31:0];
              rem <= 32'd0;
              root <= 30'd0;
              cnt <= 5'd30;
              state <= S_ROOT;
            end
          end else begin
            ax <= ax + 2'd1;
            state <= S_SQ_MUL;
          end
        end

        // one root bit a cycle over the squared length shifted up by 28
        S_ROOT: begin
          rem <= sub_ge ? sub_diff[31:0] : sub_a[31:0];
          root <= {root[28:0], sub_ge};
          rad <= {rad[29:0], 2'b00};
          cnt <= cnt - 5'd1;
          if (cnt == 5'd1) begin
            phase <= PH_MAG;
            state <= S_DIV_LOAD;
          end
        end

        S_DIV_LOAD: begin
          q <= 32'd0;
          case (phase)
            PH_MAG: begin
              divisor <= root;
              rem <= {6'd0, ad, 10'd0};
              dsh <= 32'd0;
              cnt <= 5'd18;
            end
            PH_DELTA: begin
              divisor <= {15'd0, au[ax]};
              rem <= 32'd0;
              dsh <= 32'h8000_0000;
              cnt <= 5'd31;
            end
            default: begin
              divisor <= {15'd0, au[ax]};
              rem <= 32'd0;
              dsh <= {gap, 15'd0};
              cnt <= 5'd31;
            end
          endcase
          state <= S_DIV_RUN;
        end

        // restoring divide, one quotient bit a cycle
        S_DIV_RUN: begin
          rem <= {2'b00, sub_ge ? sub_diff[29:0] : sub_a[29:0]};
          q <= q_fin;
          dsh <= {dsh[30:0], 1'b0};
          cnt <= cnt - 5'd1;
          if (cnt == 5'd1) begin
            case (phase)
              PH_MAG: begin
                // a component that rounds to zero becomes one LSB
                if (magc == 15'd0) begin
                  au[ax] <= 15'd1;
                  step_sign[ax] <= dir[ax][15] || (dir[ax] == 16'd0);
                end else begin
                  au[ax] <= magc;
                  step_sign[ax] <= dir[ax][15];
                end
              end
              PH_DELTA: delta_dist[ax] <= q_fin;
              default: side_dist[ax] <= q_fin;
            endcase
            if (ax == 2'd2) begin
              ax <= 2'd0;
              if (phase == PH_SIDE) begin
                ray_param <= 32'd0;
                steps_taken <= 16'd0;
                last_face <= 3'd0;
                ray_active <= 1'b1;
                state <= S_CHECK;
              end else begin
                phase <= phase + 2'd1;
                state <= S_DIV_LOAD;
              end
            end else begin
              ax <= ax + 2'd1;
              state <= S_DIV_LOAD;
            end
          end
        end

        // advance across the nearest face
        S_STEP: begin
          ray_param <= side_dist[sel];
          side_dist[sel] <= side_sum[32] ? 32'hFFFF_FFFF : side_sum[31:0];
          cur_voxel[sel] <= step_sign[sel] ? cur_voxel[sel] - 16'd1 : cur_voxel[sel] + 16'd1;
          last_face <= {~step_sign[sel], sel + 2'd1};
          steps_taken <= steps_taken + 16'd1;
          state <= S_CHECK;
        end

        S_CHECK: begin
          if (ray_done) begin
            ray_active <= 1'b0;
            res_kind <= RK_MISS;
          end else begin
            res_kind <= RK_QUERY;
          end
          state <= S_EMIT;
        end

        S_HIT_MUL: begin
          prod <= {16'd0, mul_a} * {32'd0, mul_b};
          state <= S_HIT_ADD;
        end

        S_HIT_ADD: begin
          hit_pt[ax] <= step_sign[ax] ? origin[ax] - off : origin[ax] + off;
          if (ax == 2'd2) begin
            ray_active <= 1'b0;
            res_kind <= RK_HIT;
            state <= S_EMIT;
          end else begin
            ax <= ax + 2'd1;
            state <= S_HIT_MUL;
          end
        end

        S_EMIT: begin
          // hold until the output register is free
          if (!rsp_valid || rsp.ready) begin
            rsp_valid <= 1'b1;
            rsp_word <= rsp_word_next;
            state <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

  `include "voxel_ray_traversal_unit_assert.svh"

  `VRT_CHECK_NEXT(a_busy_after_accept, req.valid && req.ready, !req.ready, "ready after accept")
  `VRT_CHECK_NOW(a_hit_has_face, rsp.valid && rsp.word.result_kind == RK_HIT, rsp.word.face_axis != 2'd0, "hit without face")
  `VRT_CHECK_NOW(a_dir_nonzero, ray_active && state == S_IDLE, au[0] != 15'd0 && au[1] != 15'd0 && au[2] != 15'd0, "zero unit direction")

endmodule

FILE: bench/voxel_ray_traversal_unit_test.sv
`timescale 1ns / 1ps

module voxel_ray_traversal_unit_test;
  import vrt_pkg::*;

  logic clk;
  logic rst;

  vrt_cfg_if cfg_bus();
  vrt_req_if req_bus();
  vrt_rsp_if rsp_bus();

  voxel_ray_traversal_unit uut (
    .clk(clk),
    .rst(rst),
    .cfg(cfg_bus.sink),
    .req(req_bus.sink),
    .rsp(rsp_bus.source)
  );

  // Clock: 12 ns period, high then low.
  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  // Walker state kept alongside the block.
  logic        walk_active;
  logic [15:0] walk_voxel [3];
  logic [31:0] walk_side [3];
  logic [31:0] walk_delta [3];
  logic        walk_neg [3];
  logic [31:0] walk_origin [3];
  logic [15:0] walk_mag [3];
  logic [31:0] walk_t;
  logic [15:0] walk_steps;
  logic [2:0]  walk_face;
  logic [15:0] walk_reach;

  rsp_word_t expected_words [$];
  int unsigned fail_count;
  int unsigned words_seen;
  int unsigned hits_seen;
  int unsigned misses_seen;
  int unsigned ignored_seen;

  // Integer square root, bit by bit.
  function automatic logic [63:0] root64(input logic [63:0] v);
    logic [63:0] r;
    logic [63:0] b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // Emit the next query, or end the ray on step limit, reach or height bounds.
  function automatic rsp_word_t next_query();
    rsp_word_t w;
    logic [31:0] limit;
    w = '0;
    limit = {16'd0, walk_reach >> 7} + 32'd1;
    if ({16'd0, walk_steps} >= limit || walk_t >= ({16'd0, walk_reach} << 8) ||
        $signed(walk_voxel[1]) < 0 || $signed(walk_voxel[1]) >= WORLD_HEIGHT) begin
      walk_active = 1'b0;
      w.result_kind = RK_MISS;
      return w;
    end
    w.result_kind = RK_QUERY;
    w.voxel_x = walk_voxel[0];
    w.voxel_y = walk_voxel[1][7:0];
    w.voxel_z = walk_voxel[2];
    return w;
  endfunction

  function automatic rsp_word_t walk_word(input req_word_t q);
    rsp_word_t w;
    logic signed [15:0] d [3];
    logic [31:0] raw [3];
    logic [63:0] sum;
    logic [63:0] len;
    logic [63:0] ad;
    logic [63:0] mag;
    logic [63:0] frac;
    logic [63:0] off;
    logic neg;
    int a;
    w = '0;
    d[0] = q.dir_x; d[1] = q.dir_y; d[2] = q.dir_z;
    raw[0] = q.start_x; raw[1] = q.start_y; raw[2] = q.start_z;
    if (q.operation == OP_START) begin
      sum = 0;
      for (int i = 0; i < 3; i++) sum += 64'(longint'(d[i]) * longint'(d[i]));
      if (sum == 0) begin
        walk_active = 1'b0;
        w.result_kind = RK_MISS;
        return w;
      end
      len = root64(sum << 28);
      for (int i = 0; i < 3; i++) begin
        ad = (d[i] < 0) ? 64'(-longint'(d[i])) : 64'(longint'(d[i]));
        mag = (ad << 28) / len;
        neg = (d[i] <= 0);
        frac = {48'd0, raw[i][15:0]};
        if (mag > UNIT_ONE) mag = UNIT_ONE;
        // A component that rounds to zero becomes one LSB; zero steps negative.
        if (mag == 0) mag = 1;
        else neg = (d[i] < 0);
        walk_mag[i] = mag[15:0];
        walk_neg[i] = neg;
        walk_delta[i] = 32'((64'd1 << 30) / mag);
        walk_origin[i] = raw[i];
        walk_voxel[i] = raw[i][31:16];
        if (neg) walk_side[i] = 32'((frac << 14) / mag);
        else walk_side[i] = 32'(((64'd65536 - frac) << 14) / mag);
      end
      walk_t = 0;
      walk_steps = 0;
      walk_face = 0;
      walk_active = 1'b1;
      return next_query();
    end
    if (!walk_active) begin
      w.result_kind = RK_IGNORED;
      return w;
    end
    if (q.block_kind != 0 && walk_t > HIT_T_MIN) begin
      w.result_kind = RK_HIT;
      w.voxel_x = walk_voxel[0];
      w.voxel_y = walk_voxel[1][7:0];
      w.voxel_z = walk_voxel[2];
      w.face_axis = walk_face[1:0];
      w.face_negative = walk_face[2];
      w.hit_kind = q.block_kind;
      for (int i = 0; i < 3; i++) begin
        off = ({32'd0, walk_t} * {48'd0, walk_mag[i]}) >> 14;
        raw[i] = walk_neg[i] ? walk_origin[i] - off[31:0] : walk_origin[i] + off[31:0];
      end
      w.hit_x = raw[0]; w.hit_y = raw[1]; w.hit_z = raw[2];
      walk_active = 1'b0;
      return w;
    end
    if (walk_side[0] < walk_side[1] && walk_side[0] < walk_side[2]) a = 0;
    else if (walk_side[1] < walk_side[2]) a = 1;
    else a = 2;
    walk_t = walk_side[a];
    // Saturate the side distance instead of wrapping.
    if (walk_side[a] > 32'hFFFF_FFFF - walk_delta[a]) walk_side[a] = 32'hFFFF_FFFF;
    else walk_side[a] = walk_side[a] + walk_delta[a];
    walk_voxel[a] = walk_neg[a] ? walk_voxel[a] - 16'd1 : walk_voxel[a] + 16'd1;
    walk_face = {~walk_neg[a], 2'(a + 1)};
    walk_steps = walk_steps + 16'd1;
    return next_query();
  endfunction

  // Drive one word after a random gap, hold it until accepted.
  task automatic send_word(input req_word_t q);
    int gap;
    gap = $urandom_range(0, 17);
    if ($urandom_range(0, 3) == 0) gap = 0;
    // Move off the edge where the previous word was dropped.
    @(negedge clk);
    repeat (gap) @(negedge clk);
    req_bus.word <= q;
    req_bus.valid <= 1'b1;
    @(posedge clk);
    while (!req_bus.ready) @(posedge clk);
    expected_words.push_back(walk_word(q));
    @(negedge clk);
    req_bus.valid <= 1'b0;
  endtask

  task automatic drain();
    while (expected_words.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  // Write the reach register while the block is idle.
  task automatic write_reach(input logic [15:0] value);
    drain();
    @(negedge clk);
    cfg_bus.data <= value;
    cfg_bus.valid <= 1'b1;
    @(posedge clk);
    while (!cfg_bus.ready) @(posedge clk);
    walk_reach = value;
    @(negedge clk);
    cfg_bus.valid <= 1'b0;
  endtask

  function automatic req_word_t start_word(input logic [31:0] x, input logic [31:0] y,
                                           input logic [31:0] z, input logic [15:0] dx,
                                           input logic [15:0] dy, input logic [15:0] dz);
    req_word_t q;
    q = '0;
    q.operation = OP_START;
    q.start_x = x; q.start_y = y; q.start_z = z;
    q.dir_x = dx; q.dir_y = dy; q.dir_z = dz;
    return q;
  endfunction

  function automatic req_word_t answer_word(input logic [7:0] kind);
    req_word_t q;
    q = '0;
    q.operation = OP_ANSWER;
    q.block_kind = kind;
    return q;
  endfunction

  // Answer with random content, also driving the unused fields.
  function automatic req_word_t noisy_answer(input logic [7:0] kind);
    req_word_t q;
    q = start_word($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
    q.operation = OP_ANSWER;
    q.block_kind = kind;
    return q;
  endfunction

  function automatic logic [31:0] random_origin();
    logic [31:0] v;
    case ($urandom_range(0, 3))
      0: v = $urandom;
      1: v = {16'(32'($urandom_range(0, 40)) - 32'd20), 16'($urandom)};
      default: v = {16'($urandom_range(0, 255)), 16'($urandom)};
    endcase
    return v;
  endfunction

  function automatic logic [15:0] random_dir();
    case ($urandom_range(0, 5))
      0: return 16'd0;
      1: return 16'($urandom_range(0, 4)) - 16'd2;
      2: return ($urandom_range(0, 1)) ? 16'h7FFF : 16'h8000;
      default: return $urandom;
    endcase
  endfunction

  task automatic test_zero_direction();
    send_word(start_word(32'h0001_8000, 32'h0040_0000, 32'h0, 16'd0, 16'd0, 16'd0));
    send_word(answer_word(8'd3));
  endtask

  task automatic test_axis_rays();
    send_word(start_word(32'h0000_8000, 32'h0040_8000, 32'h0000_8000, 16'd1, 16'd0, 16'd0));
    repeat (3) send_word(answer_word(8'd0));
    send_word(answer_word(8'd255));
    send_word(start_word(32'h0000_4000, 32'h0040_4000, 32'h0, 16'h8000, 16'h7FFF, 16'h8000));
    send_word(answer_word(8'd0));
    send_word(answer_word(8'd0));
    send_word(answer_word(8'd1));
  endtask

  task automatic test_height_bounds();
    // Below the floor, above the ceiling, then stepping out the bottom.
    send_word(start_word(32'h0000_0000, 32'hFFFF_8000, 32'h0, 16'd0, 16'd1, 16'd0));
    send_word(start_word(32'h0000_0000, 32'h0100_0000, 32'h0, 16'd0, 16'd1, 16'd0));
    send_word(start_word(32'h7FFF_FFFF, 32'h0000_1000, 32'h8000_0000, 16'd0, 16'hFFFF, 16'd0));
    send_word(answer_word(8'd0));
    send_word(answer_word(8'd0));
  endtask

  task automatic test_abandon_and_near_zero();
    send_word(start_word(32'h0000_0000, 32'h0010_0000, 32'h0, 16'h7FFF, 16'd1, 16'hFFFF));
    send_word(answer_word(8'd0));
    send_word(start_word(32'hFFFF_FFFF, 32'h0020_FFFF, 32'h7FFF_0000, 16'd3, 16'd4, 16'd0));
    send_word(answer_word(8'd7));
    send_word(answer_word(8'd7));
  endtask

  task automatic test_random_rays(input int count);
    int sent;
    int len;
    sent = 0;
    while (sent < count) begin
      if ($urandom_range(0, 9) == 0) begin
        send_word(noisy_answer($urandom));
        sent++;
      end
      send_word(start_word(random_origin(), random_origin(), random_origin(),
                           random_dir(), random_dir(), random_dir()));
      sent++;
      len = $urandom_range(0, 14);
      for (int k = 0; k < len && sent < count; k++) begin
        send_word(noisy_answer(($urandom_range(0, 5) == 0) ? 8'($urandom) : 8'd0));
        sent++;
      end
    end
  endtask

  // Result side: hold ready low for a drawn number of cycles per word, then take it.
  always begin : sink_side
    int idle_cycles;
    idle_cycles = $urandom_range(0, 17);
    @(negedge clk);
    if (rst) begin
      rsp_bus.ready <= 1'b0;
    end else begin
      if (idle_cycles != 0) begin
        rsp_bus.ready <= 1'b0;
        repeat (idle_cycles) @(negedge clk);
      end
      rsp_bus.ready <= 1'b1;
      do @(posedge clk); while (!rsp_bus.valid);
    end
  end

  // Compare each accepted result with the oldest expectation.
  always @(posedge clk) begin
    rsp_word_t want;
    rsp_word_t got;
    if (!rst && rsp_bus.valid && rsp_bus.ready) begin
      got = rsp_bus.word;
      words_seen++;
      if (expected_words.size() == 0) begin
        $display("%0t: unexpected word %h", $time, got);
        fail_count++;
      end else begin
        want = expected_words.pop_front();
        if (want.result_kind == RK_HIT) hits_seen++;
        if (want.result_kind == RK_MISS) misses_seen++;
        if (want.result_kind == RK_IGNORED) ignored_seen++;
        if (got !== want) begin
          $display("%0t: expected kind %0d vox %0d/%0d/%0d face %0d/%0d type %0d hit %h/%h/%h",
                   $time, want.result_kind, want.voxel_x, want.voxel_y, want.voxel_z,
                   want.face_axis, want.face_negative, want.hit_kind,
                   want.hit_x, want.hit_y, want.hit_z);
          $display("%0t: actual   kind %0d vox %0d/%0d/%0d face %0d/%0d type %0d hit %h/%h/%h",
                   $time, got.result_kind, got.voxel_x, got.voxel_y, got.voxel_z,
                   got.face_axis, got.face_negative, got.hit_kind,
                   got.hit_x, got.hit_y, got.hit_z);
          fail_count++;
        end
      end
    end
  end

  initial begin
    #80_000_000;
    $display("voxel_ray_traversal_unit: mismatch");
    $finish;
  end

  initial begin
    rst = 1'b1;
    req_bus.valid = 1'b0;
    req_bus.word = '0;
    cfg_bus.valid = 1'b0;
    cfg_bus.data = '0;
    rsp_bus.ready = 1'b0;
    fail_count = 0;
    words_seen = 0;
    hits_seen = 0;
    misses_seen = 0;
    ignored_seen = 0;
    walk_active = 1'b0;
    walk_t = 0;
    walk_steps = 0;
    walk_face = 0;
    walk_reach = REACH_RESET;
    for (int i = 0; i < 3; i++) begin
      walk_voxel[i] = 0; walk_side[i] = 0; walk_delta[i] = 0;
      walk_neg[i] = 0; walk_origin[i] = 0; walk_mag[i] = 0;
    end
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    send_word(answer_word(8'd9));
    test_zero_direction();
    test_axis_rays();
    test_height_bounds();
    test_abandon_and_near_zero();
    write_reach(16'd0);
    send_word(start_word(32'h0, 32'h0010_0000, 32'h0, 16'd1, 16'd1, 16'd1));
    write_reach(16'hFFFF);
    send_word(start_word(32'h0, 32'h0080_0000, 32'h0, 16'd1, 16'd0, 16'd0));
    repeat (4) send_word(answer_word(8'd0));
    write_reach(REACH_RESET);
    test_random_rays(300);
    write_reach(16'd384);
    test_random_rays(250);
    write_reach(16'($urandom_range(128, 65535)));
    test_random_rays(250);
    drain();

    $display("words checked: %0d (hits %0d, misses %0d, ignored %0d)",
             words_seen, hits_seen, misses_seen, ignored_seen);
    $display("reach settings zero, full scale, reset and random; mismatches %0d", fail_count);
    if (fail_count == 0 && expected_words.size() == 0) begin
      $display("voxel_ray_traversal_unit: match");
    end else begin
      $display("voxel_ray_traversal_unit: mismatch");
    end
    $finish;
  end

endmodule
